// ----- hdl/ptq_pkg.sv -----
// ptq_pkg: shared types and constants for the priority task queue
// no dependencies; used by the interfaces, the cell chain and the controller
package ptq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;

    // payload widths
    localparam int TAG_W    = 8;
    localparam int PRIO_W   = 7;
    localparam int REQ_P_W  = 8;
    localparam int STATUS_W = 3;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_NEGATIVE = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMITTED  = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // one stored queue entry
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // command broadcast to every cell
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_SHIFT
    } t_cell_cmd;

    // chain summary seen by the controller
    typedef struct packed {
        logic   full;
        logic   empty;
        logic   next_valid;
        t_entry head;
    } t_chain_stat;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } t_state;

endpackage

// ----- hdl/ptq_if.sv -----
// ptq_if: valid/ready channels for requests and responses
// depends on ptq_pkg
interface ptq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic [ptq_pkg::TAG_W-1:0]         task_tag;
    logic signed [ptq_pkg::REQ_P_W-1:0] priority_req;

    modport source (output valid, req_type, task_tag, priority_req, input ready);
    modport sink   (input valid, req_type, task_tag, priority_req, output ready);
endinterface

interface ptq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ptq_pkg::STATUS_W-1:0] status;
    logic [ptq_pkg::TAG_W-1:0]    out_tag;
    logic [ptq_pkg::PRIO_W-1:0]   out_priority;
    logic                         last;

    modport source (output valid, status, out_tag, out_priority, last, input ready);
    modport sink   (input valid, status, out_tag, out_priority, last, output ready);
endinterface

// ----- hdl/ptq_cell.sv -----
// ptq_cell: one slot of the sorted chain, holds an occupancy bit and one entry
// depends on ptq_pkg
module ptq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptq_pkg::t_cell_cmd i_cmd,
    input  ptq_pkg::t_entry    i_new,
    input  logic               i_prev_valid,
    input  logic               i_prev_place,
    input  ptq_pkg::t_entry    i_prev_entry,
    input  logic               i_next_valid,
    input  ptq_pkg::t_entry    i_next_entry,
    output logic               o_valid,
    output logic               o_place,
    output ptq_pkg::t_entry    o_entry
);
    import ptq_pkg::*;

    // occupancy bits of the chain form a thermometer code of the entry count
    logic   r_valid, n_valid;
    t_entry r_entry, n_entry;

    // new entry belongs here or earlier: slot empty or stored priority not smaller
    assign o_place = !r_valid || (i_new.prio <= r_entry.prio);
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    // next slot contents
    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        unique case (i_cmd)
            CMD_INSERT: begin
                if (i_prev_place) begin
                    n_valid = i_prev_valid;
                    n_entry = i_prev_entry;
                end else if (o_place) begin
                    n_valid = 1'b1;
                    n_entry = i_new;
                end
            end
            CMD_SHIFT: begin
                n_valid = i_next_valid;
                n_entry = i_next_entry;
            end
            default: begin
                n_valid = r_valid;
                n_entry = r_entry;
            end
        endcase
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- hdl/ptq_ctrl.sv -----
// ptq_ctrl: request decode, drain sequencer and response register
// depends on ptq_pkg and ptq_if
module ptq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ptq_req_if.sink               i_req,
    ptq_rsp_if.source             o_rsp,
    input  ptq_pkg::t_chain_stat  i_chain,
    output ptq_pkg::t_cell_cmd    o_cmd,
    output ptq_pkg::t_entry       o_new
);
    import ptq_pkg::*;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_status r_status, n_status;
    t_entry  r_out, n_out;
    logic    r_last, n_last;

    logic slot_free;
    logic accept;
    logic load;

    // response slot can take a new result this cycle
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && slot_free;
    assign accept      = i_req.valid && i_req.ready;

    // new entry for an insert, sign bit dropped
    assign o_new.tag  = i_req.task_tag;
    assign o_new.prio = i_req.priority_req[PRIO_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req.req_type == REQ_DRAIN) && !i_chain.empty) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (slot_free && !i_chain.next_valid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: cell command and response load
    always_comb begin
        o_cmd    = CMD_HOLD;
        load     = 1'b0;
        n_status = r_status;
        n_out    = '0;
        n_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == REQ_INSERT) begin
                        load = 1'b1;
                        priority if (i_req.priority_req[REQ_P_W-1]) begin
                            n_status = ST_NEGATIVE;
                        end else if (i_chain.full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_INSERTED;
                            o_cmd    = CMD_INSERT;
                        end
                    end else if (i_chain.empty) begin
                        load     = 1'b1;
                        n_status = ST_EMPTY;
                    end
                end
            end
            S_DRAIN: begin
                if (slot_free) begin
                    load     = 1'b1;
                    n_status = ST_EMITTED;
                    n_out    = i_chain.head;
                    n_last   = !i_chain.next_valid;
                    o_cmd    = CMD_SHIFT;
                end
            end
            default: begin
                o_cmd = CMD_HOLD;
            end
        endcase
    end

    // response valid
    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= n_status;
            r_out    <= n_out;
            r_last   <= n_last;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.out_tag      = r_out.tag;
    assign o_rsp.out_priority = r_out.prio;
    assign o_rsp.last         = r_last;

    // a drain never runs over an empty chain
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> !i_chain.empty)
        else $error("drain running with empty chain");

    // no insert is applied to a full chain
    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_INSERT) |-> !i_chain.full)
        else $error("insert into full chain");

    // emitting the final entry returns to idle with last set
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && slot_free && !i_chain.next_valid)
        |=> (r_state == S_IDLE && r_out_valid && r_last))
        else $error("drain did not finish on last entry");

    // a shift only happens while a result is being loaded
    a_shift_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_SHIFT) |=> (r_out_valid && r_status == ST_EMITTED))
        else $error("chain shifted without emitting");

endmodule

// ----- hdl/priority_task_queue.sv -----
// priority_task_queue: sorted task queue built from a chain of compare cells
// insert: request accepted when idle and the response slot frees; result registered next cycle
// drain: request enters the drain state, then one result per cycle while the response slot frees, last flagged
// next request is taken once the final drain result is loaded into the response register
// reset (synchronous, active low) empties the chain and clears the response valid bit
module priority_task_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptq_req_if.sink   i_req,
    ptq_rsp_if.source o_rsp
);
    import ptq_pkg::*;

    t_cell_cmd   cmd;
    t_entry      new_entry;
    t_chain_stat chain_stat;

    logic   cell_valid [QUEUE_DEPTH];
    logic   cell_place [QUEUE_DEPTH];
    t_entry cell_entry [QUEUE_DEPTH];

    // chain of cells, head at index 0
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic   prev_valid, prev_place, next_valid;
        t_entry prev_entry, next_entry;

        if (g == 0) begin : g_head
            assign prev_valid = 1'b0;
            assign prev_place = 1'b0;
            assign prev_entry = '0;
        end else begin : g_mid
            assign prev_valid = cell_valid[g-1];
            assign prev_place = cell_place[g-1];
            assign prev_entry = cell_entry[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_entry = '0;
        end else begin : g_body
            assign next_valid = cell_valid[g+1];
            assign next_entry = cell_entry[g+1];
        end

        ptq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_new        (new_entry),
            .i_prev_valid (prev_valid),
            .i_prev_place (prev_place),
            .i_prev_entry (prev_entry),
            .i_next_valid (next_valid),
            .i_next_entry (next_entry),
            .o_valid      (cell_valid[g]),
            .o_place      (cell_place[g]),
            .o_entry      (cell_entry[g])
        );
    end

    // chain summary for the controller
    assign chain_stat.full       = cell_valid[QUEUE_DEPTH-1];
    assign chain_stat.empty      = !cell_valid[0];
    assign chain_stat.next_valid = cell_valid[1];
    assign chain_stat.head       = cell_entry[0];

    // request decode and response register
    ptq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_chain (chain_stat),
        .o_cmd   (cmd),
        .o_new   (new_entry)
    );

endmodule
